FILE: src/min_max_partition_search_defines.svh
// Assertion helpers for the partition search block.
`ifndef MIN_MAX_PARTITION_SEARCH_DEFINES_SVH
`define MIN_MAX_PARTITION_SEARCH_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MMPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define MMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mmps_pkg.sv
package mmps_pkg;

	localparam int unsigned WEIGHT_W        = 16;
	localparam int unsigned SEG_W           = 11;
	localparam int unsigned CAP_W           = 26;
	localparam int unsigned MAX_ITEMS_DEF   = 1024;
	localparam int unsigned WEIGHT_BITS_DEF = 16;
	localparam logic [SEG_W-1:0] SEG_RESET  = 11'd1;

endpackage

FILE: src/min_max_partition_search.sv
// Least-capacity partition search.
// Input channel (in_valid/in_ready, weight, last): one weight per request. Each weight
// is stored and folded into a running total and maximum, one request per cycle while
// idle. Weights beyond MAX_ITEMS in one sequence are dropped.
// A request with last set starts a binary search over capacities from the largest
// weight to the total. Each trial is a greedy in-order pass over the stored weights,
// one weight per cycle through a single add/compare unit fed by the weight memory
// (registered read), and a trial ends early once the group count passes max_segments.
// The search runs about log2(total - largest + 1) + 1 trials;
// in_ready stays low throughout.
// Output channel (out_valid/out_ready, min_capacity): one result per sequence, held in
// an output register. If the receiver stalls, a finished search waits until the
// register is free, with the input side still held off.
// cfg_we/cfg_wdata write max_segments; write it only while the block is idle.
// Reset (arst_n low): empty sequence, no result pending, max_segments = 1.
// Weight memory contents are not cleared; only entries of the current sequence are read.
`include "min_max_partition_search_defines.svh"

module min_max_partition_search #(
	parameter int unsigned MAX_ITEMS   = mmps_pkg::MAX_ITEMS_DEF,
	parameter int unsigned WEIGHT_BITS = mmps_pkg::WEIGHT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mmps_pkg::SEG_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mmps_pkg::WEIGHT_W-1:0] weight,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mmps_pkg::CAP_W-1:0]  min_capacity
);

	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned GW = $clog2(MAX_ITEMS + 2);
	localparam int unsigned TW = WEIGHT_BITS + CW;
	localparam int unsigned SW = TW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MID,
		S_PASS,
		S_DEC,
		S_EMIT
	} state_t;

	state_t                      state_q;
	logic [mmps_pkg::SEG_W-1:0]  max_seg_q;
	logic [WEIGHT_BITS-1:0]      mem [MAX_ITEMS];
	logic [CW-1:0]               cnt_q;
	logic [TW-1:0]               total_q;
	logic [WEIGHT_BITS-1:0]      largest_q;
	logic [SW-1:0]               low_q;
	logic [SW-1:0]               high_q;
	logic [SW-1:0]               mid_q;
	logic [SW-1:0]               best_q;
	logic [SW-1:0]               load_q;
	logic [GW-1:0]               grp_q;
	logic                        feas_q;
	logic [CW-1:0]               rd_idx_q;
	logic [WEIGHT_BITS-1:0]      rdata_s1;
	logic                        rvld_s1;
	logic                        rlast_s1;
	logic                        out_valid_q;
	logic [mmps_pkg::CAP_W-1:0]  cap_q;

	logic                        accept;
	logic                        full;
	logic [WEIGHT_BITS-1:0]      w;
	logic [TW-1:0]               total_nx;
	logic [WEIGHT_BITS-1:0]      largest_nx;
	logic                        rd_en;
	logic [SW:0]                 sum;
	logic                        fits;
	logic [GW-1:0]               grp_nx;
	logic [SW-1:0]               load_nx;
	logic                        fail;
	logic                        emit_go;
	logic                        out_load;

	assign in_ready     = (state_q == S_IDLE);
	assign accept       = in_valid && in_ready;
	assign full         = (cnt_q == CW'(MAX_ITEMS));
	assign w            = WEIGHT_BITS'(weight);
	assign total_nx     = full ? total_q : total_q + TW'(w);
	assign largest_nx   = (!full && (w > largest_q)) ? w : largest_q;
	assign rd_en        = (state_q == S_PASS) && (rd_idx_q < cnt_q);
	assign sum          = {1'b0, load_q} + (SW + 1)'(rdata_s1);
	assign fits         = (sum <= {1'b0, mid_q});
	assign grp_nx       = fits ? grp_q : GW'(grp_q + 1'b1);
	assign load_nx      = fits ? sum[SW-1:0] : SW'(rdata_s1);
	assign fail         = (grp_nx > max_seg_q);
	assign emit_go      = !out_valid_q || out_ready;
	assign out_load     = (state_q == S_EMIT) && emit_go;
	assign out_valid    = out_valid_q;
	assign min_capacity = cap_q;

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[cnt_q[AW-1:0]] <= w;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_seg_q   <= mmps_pkg::SEG_RESET;
			cnt_q       <= '0;
			total_q     <= '0;
			largest_q   <= '0;
			low_q       <= '0;
			high_q      <= '0;
			mid_q       <= '0;
			best_q      <= '0;
			load_q      <= '0;
			grp_q       <= '0;
			feas_q      <= 1'b0;
			rd_idx_q    <= '0;
			rvld_s1     <= 1'b0;
			rlast_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cap_q       <= '0;
		end else begin
			if (cfg_we) begin
				max_seg_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!full) begin
							cnt_q <= CW'(cnt_q + 1'b1);
						end
						total_q   <= total_nx;
						largest_q <= largest_nx;
						if (last) begin
							low_q   <= SW'(largest_nx);
							high_q  <= SW'(total_nx);
							best_q  <= '0;
							state_q <= S_MID;
						end
					end
				end
				S_MID: begin
					rvld_s1  <= 1'b0;
					rd_idx_q <= '0;
					load_q   <= '0;
					grp_q    <= GW'(1);
					if (low_q > high_q) begin
						state_q <= S_EMIT;
					end else begin
						mid_q   <= SW'(({1'b0, low_q} + {1'b0, high_q}) >> 1);
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					rvld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= CW'(rd_idx_q + 1'b1);
						rlast_s1 <= (CW'(rd_idx_q + 1'b1) == cnt_q);
					end
					if (rvld_s1) begin
						load_q <= load_nx;
						grp_q  <= grp_nx;
						if (fail) begin
							feas_q  <= 1'b0;
							state_q <= S_DEC;
						end else if (rlast_s1) begin
							feas_q  <= 1'b1;
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					if (feas_q) begin
						best_q <= mid_q;
						if (mid_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							high_q  <= SW'(mid_q - 1'b1);
							state_q <= S_MID;
						end
					end else begin
						low_q   <= SW'(mid_q + 1'b1);
						state_q <= S_MID;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						cap_q       <= mmps_pkg::CAP_W'(best_q);
						cnt_q       <= '0;
						total_q     <= '0;
						largest_q   <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MMPS_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_ITEMS), "count overran store")
	`MMPS_ASSERT_NOW(a_mid_range, clk, arst_n, state_q == S_PASS,
		(mid_q >= SW'(largest_q)) && (mid_q <= SW'(total_q)), "trial capacity out of range")
	`MMPS_ASSERT_NOW(a_rd_bound, clk, arst_n, state_q == S_PASS, rd_idx_q <= cnt_q,
		"read index past count")
	`MMPS_ASSERT_NEXT(a_emit_clear, clk, arst_n, (state_q == S_EMIT) && emit_go,
		out_valid_q && (cnt_q == '0) && (state_q == S_IDLE), "result not issued cleanly")

endmodule

FILE: verif/tb_min_max_partition_search.sv
module tb_min_max_partition_search;

	localparam int unsigned CYCLE_LIMIT   = 2000000;
	localparam int unsigned HOLD_CYCLES   = 3000;
	localparam int unsigned SETTLE_CYCLES = 8;

	typedef enum int {FULL_RANGE, LOW_RANGE, EDGE_VALUES, REPEATED} weight_style_t;
	typedef enum int {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED} rx_pattern_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [mmps_pkg::SEG_W-1:0]    cfg_wdata = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic [mmps_pkg::WEIGHT_W-1:0] weight    = '0;
	logic                          last      = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [mmps_pkg::CAP_W-1:0]    min_capacity;

	// predictor state
	logic [mmps_pkg::WEIGHT_W-1:0] seq_weights[$];
	longint                        seq_total     = 0;
	longint                        seq_largest   = 0;
	logic [mmps_pkg::SEG_W-1:0]    segment_limit = mmps_pkg::SEG_RESET;
	logic [mmps_pkg::CAP_W-1:0]    pending_capacities[$];

	int unsigned fail_count    = 0;
	int unsigned cycle_count   = 0;
	bit          sender_gaps   = 1'b1;
	int          burst_left    = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;
	int          hold_left     = 0;
	rx_pattern_t rx_mode       = ALWAYS_READY;
	int          rx_phase      = 0;

	always #5 clk = ~clk;

	min_max_partition_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.weight       (weight),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.min_capacity (min_capacity)
	);

	function automatic bit packs_within(longint cap);
		longint      load;
		int unsigned groups;
		load   = 0;
		groups = 1;
		foreach (seq_weights[i]) begin
			if (load + seq_weights[i] <= cap) begin
				load += seq_weights[i];
			end else begin
				groups++;
				load = seq_weights[i];
			end
			if (groups > segment_limit)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [mmps_pkg::CAP_W-1:0] least_feasible_capacity();
		longint lo, hi, mid, best;
		lo   = seq_largest;
		hi   = seq_total;
		best = 0;
		while (lo <= hi) begin
			mid = lo + (hi - lo) / 2;
			if (packs_within(mid)) begin
				best = mid;
				hi   = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
		return best[mmps_pkg::CAP_W-1:0];
	endfunction

	// weights past a full store are dropped
	function automatic void take_weight(logic [mmps_pkg::WEIGHT_W-1:0] w, logic is_last);
		if (seq_weights.size() < mmps_pkg::MAX_ITEMS_DEF) begin
			seq_weights.push_back(w);
			seq_total += w;
			if (w > seq_largest)
				seq_largest = w;
		end
		if (is_last) begin
			pending_capacities.push_back(least_feasible_capacity());
			seq_weights.delete();
			seq_total   = 0;
			seq_largest = 0;
		end
	endfunction

	task automatic send_request(input logic [mmps_pkg::WEIGHT_W-1:0] w, input logic is_last);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left != 0)
			burst_left--;
		in_valid <= 1'b1;
		weight   <= w;
		last     <= is_last;
		do @(posedge clk); while (!in_ready);
		take_weight(w, is_last);
	endtask

	task automatic send_sequence(input int len, input weight_style_t style);
		logic [mmps_pkg::WEIGHT_W-1:0] base, w;
		base = mmps_pkg::WEIGHT_W'($urandom);
		for (int k = 0; k < len; k++) begin
			case (style)
				FULL_RANGE:  w = mmps_pkg::WEIGHT_W'($urandom);
				LOW_RANGE:   w = mmps_pkg::WEIGHT_W'($urandom_range(0, 15));
				EDGE_VALUES: w = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
				default:     w = base;
			endcase
			send_request(w, k == len - 1);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_capacities.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_segment_limit(input logic [mmps_pkg::SEG_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we        <= 1'b0;
		segment_limit = value;
	endtask

	task automatic test_directed_extremes();
		send_request(16'hFFFF, 1'b0);
		send_request(16'd0, 1'b0);
		send_request(16'd1, 1'b1);
		send_request(16'd0, 1'b1);
		write_segment_limit(11'd2);
		for (int k = 1; k <= 5; k++)
			send_request(mmps_pkg::WEIGHT_W'(k), k == 5);
		// no groups allowed
		write_segment_limit(11'd0);
		send_request(16'd7, 1'b0);
		send_request(16'd3, 1'b1);
		write_segment_limit(11'd2047);
		for (int k = 0; k < 3; k++)
			send_request(16'hFFFF, k == 2);
		write_segment_limit(11'd3);
		for (int k = 0; k < 4; k++)
			send_request(16'd0, k == 3);
		write_segment_limit(11'd1024);
		send_request(16'd40000, 1'b0);
		send_request(16'd1, 1'b0);
		send_request(16'd65534, 1'b0);
		send_request(16'd32768, 1'b1);
	endtask

	task automatic test_store_full();
		write_segment_limit(11'd5);
		for (int k = 0; k < mmps_pkg::MAX_ITEMS_DEF; k++)
			send_request(mmps_pkg::WEIGHT_W'($urandom_range(0, 30000)), 1'b0);
		// dropped: must not touch total or largest
		send_request(16'hFFFF, 1'b0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'hFFFF, 1'b1);
		send_request(16'd5, 1'b1);
		wait_idle();
	endtask

	task automatic test_backpressure();
		write_segment_limit(11'd2);
		sender_gaps   = 1'b0;
		hold_requests <= hold_requests + 1;
		for (int s = 0; s < 6; s++)
			send_sequence(4, FULL_RANGE);
		wait_idle();
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_sequences();
		logic [mmps_pkg::SEG_W-1:0] limits[8];
		int unsigned                sent;
		int                         len, pick;
		limits[0] = 11'd1;
		limits[1] = 11'd2;
		limits[2] = 11'd4;
		limits[3] = 11'd1024;
		limits[4] = 11'd2047;
		limits[5] = 11'd0;
		limits[6] = mmps_pkg::SEG_W'($urandom_range(1, 64));
		limits[7] = mmps_pkg::SEG_W'($urandom_range(1, 2047));
		for (int p = 0; p < 8; p++) begin
			write_segment_limit(limits[p]);
			sender_gaps = (p % 3) != 1;
			sent        = 0;
			while (sent < 60) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					len = $urandom_range(1, 12);
				else if (pick < 96)
					len = $urandom_range(13, 64);
				else
					len = $urandom_range(65, 200);
				send_sequence(len, weight_style_t'($urandom_range(0, 3)));
				sent += len;
				if ($urandom_range(0, 15) == 0)
					wait_idle();
			end
		end
		sender_gaps = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin : result_side
		logic [mmps_pkg::CAP_W-1:0] expected_cap;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_capacities.size() == 0) begin
					$display("%0t: result with none expected, min_capacity %0d",
						$time, min_capacity);
					fail_count++;
				end else begin
					expected_cap = pending_capacities.pop_front();
					if (min_capacity !== expected_cap) begin
						$display("%0t: min_capacity expected %0d, got %0d",
							$time, expected_cap, min_capacity);
						fail_count++;
					end
				end
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (rx_phase == 0) begin
					rx_mode  = rx_pattern_t'($urandom_range(0, 2));
					rx_phase = $urandom_range(8, 80);
				end else begin
					rx_phase--;
				end
				case (rx_mode)
					ALWAYS_READY: out_ready <= 1'b1;
					COIN_FLIP:    out_ready <= 1'($urandom_range(0, 1));
					default:      out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL min_max_partition_search");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_store_full();
		test_backpressure();
		test_random_sequences();
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS min_max_partition_search");
		end else begin
			$display("FAIL min_max_partition_search");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/mmps_pkg.sv
src/min_max_partition_search.sv
verif/tb_min_max_partition_search.sv
